// ===== hw/rtl/five_point_median_filter_assert.svh =====
// Assertion helpers for the five-point median filter.
`ifndef FIVE_POINT_MEDIAN_FILTER_ASSERT_SVH
`define FIVE_POINT_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define FPMF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpmf: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define FPMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpmf: next-cycle check failed");

`endif

// ===== hw/rtl/fpmf_pkg.sv =====
package fpmf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int WINDOW           = 5;
  localparam int HALF             = 2;
  localparam int HIST_DEPTH       = WINDOW - 1;
  localparam int MAX_RESULTS      = 3;
  localparam int QUEUE_DEPTH      = 4;

  localparam int SEEN_W = 3;
  typedef logic [SEEN_W-1:0] seen_t;
  localparam seen_t SEEN_MAX  = seen_t'(HIST_DEPTH);
  localparam seen_t SEEN_HALF = seen_t'(HALF);

endpackage

// ===== hw/rtl/fpmf_if.sv =====
interface fpmf_sample_if import fpmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface fpmf_result_if import fpmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           last_out;

  modport source (output valid, output filtered, output last_out, input ready);
  modport sink   (input valid, input filtered, input last_out, output ready);
endinterface

// ===== hw/rtl/fpmf_cell.sv =====
// One tap of the sample history: load from the left neighbor on each beat.
module fpmf_cell import fpmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           shift,
  input  logic signed [SAMPLE_WIDTH-1:0] d,
  output logic signed [SAMPLE_WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/fpmf_median.sv =====
// Rank select: each window entry counts the entries below it (ties broken
// by position), and the one ranked in the middle is the median.
module fpmf_median import fpmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic signed [SAMPLE_WIDTH-1:0] win [WINDOW],
  output logic signed [SAMPLE_WIDTH-1:0] med
);

  localparam int RW = $clog2(WINDOW);

  logic [RW-1:0]     rank [WINDOW];
  logic [WINDOW-1:0] pick;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + RW'(1);
          end
        end
      end
      pick[i] = (rank[i] == RW'(HALF));
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (pick[i]) begin
        med = med | win[i];
      end
    end
  end

endmodule

// ===== hw/rtl/five_point_median_filter.sv =====
// Channel   Dir  Payload                          Beat when
// samples   in   sample[SAMPLE_WIDTH], last       valid && ready
// results   out  filtered[SAMPLE_WIDTH], last_out valid && ready
//
// One sample per cycle while the result side keeps up; each beat's results
// are registered into a 4-entry queue, which hands them out one per cycle
// while the result side is ready. A final sample queues up to three results,
// so the sample side holds ready low while the queue drains.
// Synchronous reset clears the stream count and the queue; history is not
// cleared, it is always rewritten before it is read.
// A stall on the result side backs up into the sample side once two results wait.
`include "five_point_median_filter_assert.svh"

module five_point_median_filter import fpmf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  fpmf_sample_if.sink      samples,
  fpmf_result_if.source    results
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = $clog2(QUEUE_DEPTH);

  typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
  typedef struct packed {
    smp_t filtered;
    logic last_out;
  } entry_t;

  logic   in_acc;
  logic   out_acc;
  smp_t   x;
  logic   fin;

  smp_t   hist [HIST_DEPTH];
  smp_t   win  [WINDOW];
  smp_t   med;

  seen_t  seen_count;
  seen_t  seen_count_next;

  entry_t q [QUEUE_DEPTH];
  entry_t q_next [QUEUE_DEPTH];
  logic [QCW-1:0] q_count;
  logic [QCW-1:0] q_count_next;

  entry_t cand [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] cand_vld;

  assign x       = samples.sample;
  assign fin     = samples.last;
  assign in_acc  = samples.valid && samples.ready;
  assign out_acc = results.valid && results.ready;

  // Room for a full burst of results even if nothing is popped this cycle.
  assign samples.ready = (q_count <= QCW'(QUEUE_DEPTH - MAX_RESULTS));

  assign results.valid    = (q_count != '0);
  assign results.filtered = q[0].filtered;
  assign results.last_out = q[0].last_out;

  // History line: hist[0] is the newest earlier sample, each cell loads from
  // its neighbor on every beat.
  for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_hist
    if (g == 0) begin : g_head
      fpmf_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk   (clk),
        .shift (in_acc),
        .d     (x),
        .q     (hist[g])
      );
    end else begin : g_tail
      fpmf_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk   (clk),
        .shift (in_acc),
        .d     (hist[g-1]),
        .q     (hist[g])
      );
    end
  end

  // Window oldest first, the incoming sample last.
  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      win[i] = hist[HIST_DEPTH-1-i];
    end
    win[WINDOW-1] = x;
  end

  fpmf_median #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_median (
    .win (win),
    .med (med)
  );

  // Candidate results of this beat, in output order: the lagged output
  // (median once the window is full, else the sample two back), then on the
  // final sample the previous sample and the sample itself.
  always_comb begin
    cand[0].filtered = (seen_count >= SEEN_MAX) ? med : hist[1];
    cand[0].last_out = 1'b0;
    cand[1].filtered = hist[0];
    cand[1].last_out = 1'b0;
    cand[2].filtered = x;
    cand[2].last_out = 1'b1;
    cand_vld[0] = (seen_count >= SEEN_HALF);
    cand_vld[1] = fin && (seen_count != '0);
    cand_vld[2] = fin;
  end

  // Queue: drop the head on a pop, then append the valid candidates packed.
  always_comb begin
    logic [QCW-1:0] pos;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      q_next[i] = out_acc ? q[i+1] : q[i];
    end
    q_next[QUEUE_DEPTH-1] = q[QUEUE_DEPTH-1];
    pos = q_count - QCW'(out_acc);
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (in_acc && cand_vld[k]) begin
        q_next[pos[QIW-1:0]] = cand[k];
        pos = pos + QCW'(1);
      end
    end
    q_count_next = pos;
  end

  // Stream count: restart after the final sample, saturate once full.
  always_comb begin
    seen_count_next = seen_count;
    if (in_acc) begin
      if (fin) begin
        seen_count_next = '0;
      end else if (seen_count < SEEN_MAX) begin
        seen_count_next = seen_count + seen_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      q_count    <= '0;
      seen_count <= '0;
    end else begin
      q_count    <= q_count_next;
      seen_count <= seen_count_next;
    end
  end

  // A final sample always leaves at least its own result queued.
  `FPMF_ASSERT_NEXT(a_fin_queued, clk, rst, in_acc && fin, q_count != '0)
  // The stream count restarts after a final sample.
  `FPMF_ASSERT_NEXT(a_fin_restart, clk, rst, in_acc && fin, seen_count == '0)
  // Queue never overfills and the count never passes its saturation point.
  `FPMF_ASSERT_NOW(a_bounds, clk, rst, 1'b1,
                   (q_count <= QCW'(QUEUE_DEPTH)) && (seen_count <= SEEN_MAX))

endmodule
